// ===== rtl/core/pgmd_pkg.sv =====
// Shared types, codes and helpers for the PGM stream decoder.
package pgmd_pkg;

    // Default limit on image width and height
    localparam int MAX_DIM_DEF = 4096;

    // Result status codes
    localparam logic [2:0] STATUS_PIXEL  = 3'd0;
    localparam logic [2:0] STATUS_MAGIC  = 3'd1;
    localparam logic [2:0] STATUS_NUMBER = 3'd2;
    localparam logic [2:0] STATUS_SIZE   = 3'd3;
    localparam logic [2:0] STATUS_TRUNC  = 3'd4;

    // Header and token characters
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Saturation point of the token accumulator (2^31 + 1)
    localparam logic [31:0] TOK_CAP   = 32'h8000_0001;
    localparam logic [31:0] LIM_POS   = 32'h7FFF_FFFF;
    localparam logic [31:0] LIM_NEG   = 32'h8000_0000;
    // Largest maxval that needs no scaling
    localparam logic [30:0] LEVEL_MAX = 31'd255;

    // Dividend, divisor and quotient widths of the scaling divider
    localparam int DIV_NW = 41;
    localparam int DIV_DW = 32;
    localparam int DIV_QW = 8;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  pixel_value;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last_pixel;
    } t_out_item;

    // Space, LF, CR or TAB
    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h09);
    endfunction

endpackage

// ===== rtl/core/pgmd_div.sv =====
// Restoring divider, one quotient bit per cycle, for sample scaling.
module pgmd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pgmd_pkg::DIV_NW-1:0]   i_num,
    input  logic [pgmd_pkg::DIV_DW-1:0]   i_den,
    output logic                          o_done,
    output logic [pgmd_pkg::DIV_QW-1:0]   o_quot
);

    localparam int SW = pgmd_pkg::DIV_DW + pgmd_pkg::DIV_QW - 1;
    localparam int CW = $clog2(pgmd_pkg::DIV_QW);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [pgmd_pkg::DIV_NW-1:0]  r_rem, n_rem;
    logic [SW-1:0]                r_dsh, n_dsh;
    logic [pgmd_pkg::DIV_QW-1:0]  r_quot, n_quot;
    logic [pgmd_pkg::DIV_NW-1:0]  w_dsh_ext;
    logic                         w_fit;

    assign w_dsh_ext = pgmd_pkg::DIV_NW'(r_dsh);
    assign w_fit     = (r_rem >= w_dsh_ext);

    // Step: subtract the shifted divisor where it fits
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_dsh  = SW'(i_den) << (pgmd_pkg::DIV_QW - 1);
            n_quot = '0;
        end else if (r_busy) begin
            if (w_fit) begin
                n_rem = r_rem - w_dsh_ext;
            end
            n_quot = {r_quot[pgmd_pkg::DIV_QW-2:0], w_fit};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CW'(pgmd_pkg::DIV_QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/pgm_stream_decoder.sv =====
// Top level: PGM (P2/P5) byte stream parser with sample scaling sequencer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// A byte that yields no result passes through ST_IDLE and ST_BYTE; the
// end-of-file mark adds ST_EOFTOK and ST_EOFCHK, and ST_EOFTOK repeats when
// it closes an open token. A pixel adds ST_SCALE and ST_PIX, and ST_DIV for
// the 8-step divider when maxval exceeds 255. Each error result adds ST_ERR.
// Reset is synchronous, active low, and returns the parser to the magic search.
// A stalled output holds the sequencer; the input stalls until the byte is done.
module pgm_stream_decoder #(
    parameter int MAX_DIM = pgmd_pkg::MAX_DIM_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pgmd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pgmd_pkg::t_out_item o_out_data
);

    localparam int DW = $clog2(MAX_DIM + 1);

    typedef enum logic [3:0] {
        PH_MAGIC_WS, PH_MAGIC_DIGIT, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
        PH_BIN, PH_ASC, PH_DONE, PH_ERROR
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BYTE, ST_EOFTOK, ST_EOFCHK, ST_ERR, ST_SCALE, ST_DIV, ST_PIX
    } t_state;

    t_state              r_st, n_st;
    t_phase              r_phase, n_phase;
    logic                r_ascii, n_ascii;
    logic                r_comment, n_comment;
    logic [31:0]         r_tok_val, n_tok_val;
    logic                r_tok_neg, n_tok_neg;
    logic                r_tok_open, n_tok_open;
    logic                r_tok_digit, n_tok_digit;
    logic                r_tok_sign, n_tok_sign;
    logic                r_tok_bad, n_tok_bad;
    logic                r_size_bad, n_size_bad;
    logic [DW-1:0]       r_width, n_width;
    logic [DW-1:0]       r_height, n_height;
    logic [30:0]         r_maxval, n_maxval;
    logic [DW-1:0]       r_col, n_col;
    logic [DW-1:0]       r_row, n_row;
    logic [7:0]          r_high, n_high;
    logic                r_high_pend, n_high_pend;
    logic [7:0]          r_byte, n_byte;
    logic                r_eof, n_eof;
    logic [2:0]          r_err, n_err;
    logic [11:0]         r_px_x, n_px_x;
    logic [11:0]         r_px_y, n_px_y;
    logic                r_px_last, n_px_last;
    logic [31:0]         r_samp, n_samp;
    logic                r_samp_neg, n_samp_neg;
    logic [7:0]          r_q, n_q;
    logic                r_out_valid, n_out_valid;
    pgmd_pkg::t_out_item r_out, n_out;

    logic                          w_div_start;
    logic [pgmd_pkg::DIV_NW-1:0]   w_div_num;
    logic [pgmd_pkg::DIV_DW-1:0]   w_div_den;
    logic                          w_div_done;
    logic [pgmd_pkg::DIV_QW-1:0]   w_div_quot;

    pgmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Numerator 510*s + M and divisor 2*M
    assign w_div_num = (pgmd_pkg::DIV_NW'(r_samp) << 9) - (pgmd_pkg::DIV_NW'(r_samp) << 1)
                     + pgmd_pkg::DIV_NW'(r_maxval);
    assign w_div_den = {r_maxval, 1'b0};

    // Parse sequencer
    always_comb begin
        logic        out_free;
        logic        ws;
        logic        px_req;
        logic        err_req;
        logic [2:0]  err_code;
        logic [31:0] px_val;
        logic        px_neg;
        logic        do_tok_end;
        logic        te_bad;
        logic        dim_ok;
        logic [31:0] base_val;
        logic        base_digit;
        logic        base_sign;
        logic [35:0] acc;
        logic        col_end;
        logic        row_end;
        t_state      ret_st;

        n_st        = r_st;
        n_phase     = r_phase;
        n_ascii     = r_ascii;
        n_comment   = r_comment;
        n_tok_val   = r_tok_val;
        n_tok_neg   = r_tok_neg;
        n_tok_open  = r_tok_open;
        n_tok_digit = r_tok_digit;
        n_tok_sign  = r_tok_sign;
        n_tok_bad   = r_tok_bad;
        n_size_bad  = r_size_bad;
        n_width     = r_width;
        n_height    = r_height;
        n_maxval    = r_maxval;
        n_col       = r_col;
        n_row       = r_row;
        n_high      = r_high;
        n_high_pend = r_high_pend;
        n_byte      = r_byte;
        n_eof       = r_eof;
        n_err       = r_err;
        n_px_x      = r_px_x;
        n_px_y      = r_px_y;
        n_px_last   = r_px_last;
        n_samp      = r_samp;
        n_samp_neg  = r_samp_neg;
        n_q         = r_q;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_div_start = 1'b0;

        out_free   = !r_out_valid || !i_out_stall;
        ws         = pgmd_pkg::is_ws(r_byte);
        px_req     = 1'b0;
        err_req    = 1'b0;
        err_code   = pgmd_pkg::STATUS_PIXEL;
        px_val     = '0;
        px_neg     = 1'b0;
        do_tok_end = 1'b0;
        ret_st     = r_eof ? ST_EOFTOK : ST_IDLE;

        // Raster position checks for the next pixel
        col_end    = ({1'b0, r_col} + 1'b1) >= {1'b0, r_width};
        row_end    = ({1'b0, r_row} + 1'b1) >= {1'b0, r_height};

        // Token accumulate on the current byte, from a fresh token if none is open
        base_val   = r_tok_open ? r_tok_val : '0;
        base_digit = r_tok_open && r_tok_digit;
        base_sign  = r_tok_open && r_tok_sign;
        acc        = (36'(base_val) << 3) + (36'(base_val) << 1)
                   + 36'(r_byte - pgmd_pkg::CH_ZERO);

        // Token end checks on the registered token
        te_bad = r_tok_bad || !r_tok_digit
              || (r_tok_val > (r_tok_neg ? pgmd_pkg::LIM_NEG : pgmd_pkg::LIM_POS));
        dim_ok = !r_tok_neg && (r_tok_val != '0) && (r_tok_val <= 32'(MAX_DIM));

        unique case (r_st)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_in_data.file_byte;
                    n_eof  = i_in_data.end_of_file;
                    n_st   = ST_BYTE;
                end
            end
            ST_BYTE: begin
                n_st = ret_st;
                unique case (r_phase)
                    PH_MAGIC_WS: begin
                        if (r_byte == pgmd_pkg::CH_P) begin
                            n_phase = PH_MAGIC_DIGIT;
                        end else if (!ws) begin
                            err_req  = 1'b1;
                            err_code = pgmd_pkg::STATUS_MAGIC;
                        end
                    end
                    PH_MAGIC_DIGIT: begin
                        if (r_byte == pgmd_pkg::CH_5 || r_byte == pgmd_pkg::CH_2) begin
                            n_ascii = (r_byte == pgmd_pkg::CH_2);
                            n_phase = PH_WIDTH;
                        end else begin
                            err_req  = 1'b1;
                            err_code = pgmd_pkg::STATUS_MAGIC;
                        end
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASC: begin
                        priority if (r_comment) begin
                            if (r_byte == pgmd_pkg::CH_LF) begin
                                n_comment = 1'b0;
                            end
                        end else if (r_tok_open && ws) begin
                            do_tok_end = 1'b1;
                        end else if (!r_tok_open && ws) begin
                            n_comment = 1'b0;
                        end else if (!r_tok_open && r_byte == pgmd_pkg::CH_HASH) begin
                            n_comment = 1'b1;
                        end else begin
                            // Add the byte to the token
                            n_tok_open  = 1'b1;
                            n_tok_val   = base_val;
                            n_tok_neg   = r_tok_open && r_tok_neg;
                            n_tok_digit = base_digit;
                            n_tok_sign  = base_sign;
                            n_tok_bad   = r_tok_open && r_tok_bad;
                            if (r_byte >= pgmd_pkg::CH_ZERO && r_byte <= pgmd_pkg::CH_NINE) begin
                                n_tok_val   = (acc > 36'(pgmd_pkg::TOK_CAP))
                                            ? pgmd_pkg::TOK_CAP : acc[31:0];
                                n_tok_digit = 1'b1;
                            end else if ((r_byte == pgmd_pkg::CH_PLUS ||
                                          r_byte == pgmd_pkg::CH_MINUS) &&
                                         !base_digit && !base_sign) begin
                                n_tok_sign = 1'b1;
                                n_tok_neg  = (r_byte == pgmd_pkg::CH_MINUS);
                            end else begin
                                n_tok_bad = 1'b1;
                            end
                        end
                    end
                    PH_BIN: begin
                        if (r_maxval <= pgmd_pkg::LEVEL_MAX) begin
                            px_req = 1'b1;
                            px_val = 32'(r_byte);
                        end else if (!r_high_pend) begin
                            n_high      = r_byte;
                            n_high_pend = 1'b1;
                        end else begin
                            n_high_pend = 1'b0;
                            px_req      = 1'b1;
                            px_val      = 32'({r_high, r_byte});
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            ST_EOFTOK: begin
                n_st = ST_EOFCHK;
                if (r_tok_open && (r_phase == PH_WIDTH || r_phase == PH_HEIGHT ||
                                   r_phase == PH_MAXVAL || r_phase == PH_ASC)) begin
                    do_tok_end = 1'b1;
                    n_st       = ST_EOFTOK;
                end
            end
            ST_EOFCHK: begin
                priority if (r_phase == PH_MAGIC_WS || r_phase == PH_MAGIC_DIGIT) begin
                    err_req  = 1'b1;
                    err_code = pgmd_pkg::STATUS_MAGIC;
                end else if (r_phase != PH_DONE && r_phase != PH_ERROR) begin
                    err_req  = 1'b1;
                    err_code = pgmd_pkg::STATUS_TRUNC;
                end else begin
                    // Back to the reset state for the next file
                    n_st        = ST_IDLE;
                    n_phase     = PH_MAGIC_WS;
                    n_ascii     = 1'b0;
                    n_comment   = 1'b0;
                    n_tok_val   = '0;
                    n_tok_neg   = 1'b0;
                    n_tok_open  = 1'b0;
                    n_tok_digit = 1'b0;
                    n_tok_sign  = 1'b0;
                    n_tok_bad   = 1'b0;
                    n_size_bad  = 1'b0;
                    n_width     = '0;
                    n_height    = '0;
                    n_maxval    = '0;
                    n_col       = '0;
                    n_row       = '0;
                    n_high      = '0;
                    n_high_pend = 1'b0;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.status = r_err;
                    n_st        = ret_st;
                end
            end
            ST_SCALE: begin
                n_st = ST_PIX;
                priority if (r_samp_neg) begin
                    n_q = '0;
                end else if (r_maxval <= pgmd_pkg::LEVEL_MAX) begin
                    n_q = (r_samp > 32'd255) ? 8'hFF : r_samp[7:0];
                end else if (r_samp >= 32'(r_maxval)) begin
                    n_q = 8'hFF;
                end else begin
                    w_div_start = 1'b1;
                    n_st        = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_q  = w_div_quot;
                    n_st = ST_PIX;
                end
            end
            ST_PIX: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = pgmd_pkg::STATUS_PIXEL;
                    n_out.pixel_value    = r_q;
                    n_out.pixel_x        = r_px_x;
                    n_out.pixel_y        = r_px_y;
                    n_out.image_width    = 13'(r_width);
                    n_out.image_height   = 13'(r_height);
                    n_out.last_pixel     = r_px_last;
                    n_st                 = ret_st;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase

        // End of a token: header field, pixel sample or bad number
        if (do_tok_end) begin
            n_tok_open = 1'b0;
            if (te_bad) begin
                err_req  = 1'b1;
                err_code = pgmd_pkg::STATUS_NUMBER;
            end else begin
                unique case (r_phase)
                    PH_WIDTH: begin
                        if (dim_ok) n_width = r_tok_val[DW-1:0];
                        else n_size_bad = 1'b1;
                        n_phase = PH_HEIGHT;
                    end
                    PH_HEIGHT: begin
                        if (dim_ok) n_height = r_tok_val[DW-1:0];
                        else n_size_bad = 1'b1;
                        n_phase = PH_MAXVAL;
                    end
                    PH_MAXVAL: begin
                        n_maxval = r_tok_neg ? '0 : r_tok_val[30:0];
                        if (r_size_bad) begin
                            err_req  = 1'b1;
                            err_code = pgmd_pkg::STATUS_SIZE;
                        end else begin
                            n_phase = r_ascii ? PH_ASC : PH_BIN;
                        end
                    end
                    default: begin
                        px_req = 1'b1;
                        px_val = r_tok_val;
                        px_neg = r_tok_neg;
                    end
                endcase
            end
        end

        // Latch pixel position and advance the raster
        if (px_req) begin
            n_px_x     = 12'(r_col);
            n_px_y     = 12'(r_row);
            n_px_last  = col_end && row_end;
            n_samp     = px_val;
            n_samp_neg = px_neg;
            n_st       = ST_SCALE;
            priority if (col_end && row_end) begin
                n_phase = PH_DONE;
            end else if (col_end) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end

        // Drop into the error phase and queue the error item
        if (err_req) begin
            n_phase = PH_ERROR;
            n_err   = err_code;
            n_st    = ST_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_phase     <= PH_MAGIC_WS;
            r_ascii     <= 1'b0;
            r_comment   <= 1'b0;
            r_tok_val   <= '0;
            r_tok_neg   <= 1'b0;
            r_tok_open  <= 1'b0;
            r_tok_digit <= 1'b0;
            r_tok_sign  <= 1'b0;
            r_tok_bad   <= 1'b0;
            r_size_bad  <= 1'b0;
            r_width     <= '0;
            r_height    <= '0;
            r_maxval    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_high      <= '0;
            r_high_pend <= 1'b0;
            r_eof       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_phase     <= n_phase;
            r_ascii     <= n_ascii;
            r_comment   <= n_comment;
            r_tok_val   <= n_tok_val;
            r_tok_neg   <= n_tok_neg;
            r_tok_open  <= n_tok_open;
            r_tok_digit <= n_tok_digit;
            r_tok_sign  <= n_tok_sign;
            r_tok_bad   <= n_tok_bad;
            r_size_bad  <= n_size_bad;
            r_width     <= n_width;
            r_height    <= n_height;
            r_maxval    <= n_maxval;
            r_col       <= n_col;
            r_row       <= n_row;
            r_high      <= n_high;
            r_high_pend <= n_high_pend;
            r_eof       <= n_eof;
            r_out_valid <= n_out_valid;
        end
        r_byte     <= n_byte;
        r_err      <= n_err;
        r_px_x     <= n_px_x;
        r_px_y     <= n_px_y;
        r_px_last  <= n_px_last;
        r_samp     <= n_samp;
        r_samp_neg <= n_samp_neg;
        r_q        <= n_q;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_st != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An error item carries nothing but its status
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != pgmd_pkg::STATUS_PIXEL) |->
        (o_out_data.pixel_value == '0 && o_out_data.pixel_x == '0 &&
         o_out_data.pixel_y == '0 && o_out_data.image_width == '0 &&
         o_out_data.image_height == '0 && !o_out_data.last_pixel))
        else $error("error item with nonzero payload");

    // A pixel column lies inside the parsed width
    a_pix_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == pgmd_pkg::STATUS_PIXEL) |->
        (13'(o_out_data.pixel_x) < o_out_data.image_width ||
         o_out_data.image_width == '0))
        else $error("pixel column outside image width");

    // The divider reports only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_st == ST_DIV))
        else $error("divider finished outside its wait state");

    // A loaded pixel leaves the sequencer in its return state
    a_pix_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_PIX && (!r_out_valid || !i_out_stall)) |=>
        (r_st == ST_EOFTOK || r_st == ST_IDLE))
        else $error("sequencer lost its way after a pixel");

endmodule
